// File: rtl/core/eaf_pkg.sv
// Shared types and constants of the escaped API frame encoder.
`default_nettype none

package eaf_pkg;

  // Line bytes and framing constants
  localparam logic [7:0] START_MARK = 8'h7E;
  localparam logic [7:0] ESC_MARK   = 8'h7D;
  localparam logic [7:0] XON_MARK   = 8'h11;
  localparam logic [7:0] XOFF_MARK  = 8'h13;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] CHK_BASE   = 8'hFF;
  localparam logic [8:0] HDR_EXTRA  = 9'd14;

  // Input item kinds
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NET_ADDR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPTIONS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ID  = 3'd6;
  localparam int CFG_DATA_W = 32;

  // Back-end sequencer steps: header bytes 0..16, then checksum, payload
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_START  = 5'd0;
  localparam logic [STEP_W-1:0] STEP_LEN_HI = 5'd1;
  localparam logic [STEP_W-1:0] STEP_LEN_LO = 5'd2;
  localparam logic [STEP_W-1:0] STEP_FTYPE  = 5'd3;
  localparam logic [STEP_W-1:0] STEP_FID    = 5'd4;
  localparam logic [STEP_W-1:0] STEP_DH3    = 5'd5;
  localparam logic [STEP_W-1:0] STEP_DH2    = 5'd6;
  localparam logic [STEP_W-1:0] STEP_DH1    = 5'd7;
  localparam logic [STEP_W-1:0] STEP_DH0    = 5'd8;
  localparam logic [STEP_W-1:0] STEP_DL3    = 5'd9;
  localparam logic [STEP_W-1:0] STEP_DL2    = 5'd10;
  localparam logic [STEP_W-1:0] STEP_DL1    = 5'd11;
  localparam logic [STEP_W-1:0] STEP_DL0    = 5'd12;
  localparam logic [STEP_W-1:0] STEP_NET1   = 5'd13;
  localparam logic [STEP_W-1:0] STEP_NET0   = 5'd14;
  localparam logic [STEP_W-1:0] STEP_RADIUS = 5'd15;
  localparam logic [STEP_W-1:0] STEP_OPTS   = 5'd16;
  localparam logic [STEP_W-1:0] STEP_CHK    = 5'd17;
  localparam logic [STEP_W-1:0] STEP_PAY    = 5'd18;

  // Command queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // Classified command: header (value = length) or payload (value = byte);
  // last marks that the checksum follows this command.
  typedef struct packed {
    logic       is_pay;
    logic       last;
    logic [7:0] value;
  } cmd_t;

  typedef struct packed {
    logic [31:0] dest_addr_high;
    logic [31:0] dest_addr_low;
    logic [15:0] dest_net_addr;
    logic [7:0]  hop_radius;
    logic [7:0]  tx_options;
    logic [7:0]  frame_type;
    logic [7:0]  frame_ident;
  } cfg_t;

  // Front to queue push request
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  // Queue status toward both sides
  typedef struct packed {
    logic valid;
    logic full;
    cmd_t head;
  } qstat_t;

endpackage

`default_nettype wire

// File: rtl/core/eaf_cfg.sv
// Configuration register file of the frame encoder.
`default_nettype none

module eaf_cfg (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              wr_en,
  input  wire [eaf_pkg::CFG_IDX_W-1:0]     wr_index,
  input  wire [eaf_pkg::CFG_DATA_W-1:0]    wr_data,
  output eaf_pkg::cfg_t                    cfg
);

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_addr_high <= 32'd0;
      cfg.dest_addr_low  <= 32'd0;
      cfg.dest_net_addr  <= 16'hFFFE;
      cfg.hop_radius     <= 8'd0;
      cfg.tx_options     <= 8'd0;
      cfg.frame_type     <= 8'h10;
      cfg.frame_ident    <= 8'h01;
    end else if (wr_en) begin
      unique case (wr_index)
        eaf_pkg::REG_DEST_HIGH: cfg.dest_addr_high <= wr_data;
        eaf_pkg::REG_DEST_LOW:  cfg.dest_addr_low  <= wr_data;
        eaf_pkg::REG_NET_ADDR:  cfg.dest_net_addr  <= wr_data[15:0];
        eaf_pkg::REG_RADIUS:    cfg.hop_radius     <= wr_data[7:0];
        eaf_pkg::REG_OPTIONS:   cfg.tx_options     <= wr_data[7:0];
        eaf_pkg::REG_FRAME_TYP: cfg.frame_type     <= wr_data[7:0];
        eaf_pkg::REG_FRAME_ID:  cfg.frame_ident    <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/eaf_front.sv
// Front end: accepts input items, tracks frame state, classifies commands.
`default_nettype none

module eaf_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_ready,
  input  eaf_pkg::in_item_t   item,
  input  eaf_pkg::qstat_t     qstat,
  output eaf_pkg::push_t      push
);

  logic       in_frame;
  logic [7:0] bytes_left;
  logic       accept;

  assign item_ready = !qstat.full;
  assign accept     = item_valid && item_ready;

  // Classify: header, payload, or stray payload that is dropped
  always_comb begin
    push.push = 1'b0;
    push.cmd  = '0;
    if (accept) begin
      if (item.kind == eaf_pkg::KIND_START) begin
        push.push       = 1'b1;
        push.cmd.is_pay = 1'b0;
        push.cmd.last   = (item.payload_length == 8'd0);
        push.cmd.value  = item.payload_length;
      end else if (in_frame) begin
        push.push       = 1'b1;
        push.cmd.is_pay = 1'b1;
        push.cmd.last   = (bytes_left == 8'd1);
        push.cmd.value  = item.payload_byte;
      end
    end
  end

  // Frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      bytes_left <= 8'd0;
    end else if (accept) begin
      if (item.kind == eaf_pkg::KIND_START) begin
        in_frame   <= (item.payload_length != 8'd0);
        bytes_left <= item.payload_length;
      end else if (in_frame) begin
        bytes_left <= bytes_left - 8'd1;
        in_frame   <= (bytes_left != 8'd1);
      end
    end
  end

`ifndef SYNTHESIS
  // An open frame always expects at least one more payload byte
  assert property (@(posedge clk) disable iff (rst) in_frame |-> (bytes_left != 8'd0))
    else $error("open frame with no bytes left");
`endif

endmodule

`default_nettype wire

// File: rtl/core/eaf_queue.sv
// Short command queue between front and back ends.
`default_nettype none

module eaf_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  eaf_pkg::push_t      push,
  input  wire                 pop,
  output eaf_pkg::qstat_t     qstat
);

  eaf_pkg::cmd_t                 mem [eaf_pkg::QDEPTH];
  logic [eaf_pkg::QPTR_W-1:0]    wr_ptr;
  logic [eaf_pkg::QPTR_W-1:0]    rd_ptr;
  logic [eaf_pkg::QCNT_W-1:0]    count;
  logic                          do_pop;

  assign do_pop      = pop && (count != '0);
  assign qstat.valid = (count != '0);
  assign qstat.full  = (count == eaf_pkg::QCNT_W'(eaf_pkg::QDEPTH));
  assign qstat.head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push.push) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= (wr_ptr == eaf_pkg::QPTR_W'(eaf_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == eaf_pkg::QPTR_W'(eaf_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push.push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  // No push into a full queue, no pop from an empty one
  assert property (@(posedge clk) disable iff (rst)
      (push.push |-> !qstat.full) and (pop |-> qstat.valid))
    else $error("queue overflow or underflow");
`endif

endmodule

`default_nettype wire

// File: rtl/core/eaf_back.sv
// Back end: sequences header, payload and checksum bytes with escaping.
`default_nettype none

module eaf_back (
  input  wire                 clk,
  input  wire                 rst,
  input  eaf_pkg::cfg_t       cfg,
  input  eaf_pkg::qstat_t     qstat,
  output logic                pop,
  output logic                result_valid,
  input  wire                 result_ready,
  output eaf_pkg::out_item_t  result
);

  logic [eaf_pkg::STEP_W-1:0] step;
  logic [eaf_pkg::STEP_W-1:0] step_next;
  logic [eaf_pkg::STEP_W-1:0] eff;
  logic                       esc_ph;
  logic [7:0]                 sum;
  logic [7:0]                 lbyte;
  logic [7:0]                 line_byte;
  logic [8:0]                 flen;
  logic                       special;
  logic                       advance;
  logic                       done;
  logic                       summed;
  logic                       emit;

  assign flen = {1'b0, qstat.head.value} + eaf_pkg::HDR_EXTRA;
  assign eff  = (qstat.head.is_pay && step == eaf_pkg::STEP_START) ?
                eaf_pkg::STEP_PAY : step;

  // Logical byte of the current step
  always_comb begin
    summed = 1'b1;
    unique case (eff)
      eaf_pkg::STEP_START:  begin lbyte = eaf_pkg::START_MARK; summed = 1'b0; end
      eaf_pkg::STEP_LEN_HI: begin lbyte = {7'd0, flen[8]};     summed = 1'b0; end
      eaf_pkg::STEP_LEN_LO: begin lbyte = flen[7:0];           summed = 1'b0; end
      eaf_pkg::STEP_FTYPE:  lbyte = cfg.frame_type;
      eaf_pkg::STEP_FID:    lbyte = cfg.frame_ident;
      eaf_pkg::STEP_DH3:    lbyte = cfg.dest_addr_high[31:24];
      eaf_pkg::STEP_DH2:    lbyte = cfg.dest_addr_high[23:16];
      eaf_pkg::STEP_DH1:    lbyte = cfg.dest_addr_high[15:8];
      eaf_pkg::STEP_DH0:    lbyte = cfg.dest_addr_high[7:0];
      eaf_pkg::STEP_DL3:    lbyte = cfg.dest_addr_low[31:24];
      eaf_pkg::STEP_DL2:    lbyte = cfg.dest_addr_low[23:16];
      eaf_pkg::STEP_DL1:    lbyte = cfg.dest_addr_low[15:8];
      eaf_pkg::STEP_DL0:    lbyte = cfg.dest_addr_low[7:0];
      eaf_pkg::STEP_NET1:   lbyte = cfg.dest_net_addr[15:8];
      eaf_pkg::STEP_NET0:   lbyte = cfg.dest_net_addr[7:0];
      eaf_pkg::STEP_RADIUS: lbyte = cfg.hop_radius;
      eaf_pkg::STEP_OPTS:   lbyte = cfg.tx_options;
      eaf_pkg::STEP_CHK:    begin lbyte = eaf_pkg::CHK_BASE - sum; summed = 1'b0; end
      eaf_pkg::STEP_PAY:    lbyte = qstat.head.value;
      default:              begin lbyte = 8'd0; summed = 1'b0; end
    endcase
  end

  // Escaping: marker first, then the flipped byte
  always_comb begin
    special = (eff != eaf_pkg::STEP_START) &&
              (lbyte == eaf_pkg::START_MARK || lbyte == eaf_pkg::ESC_MARK ||
               lbyte == eaf_pkg::XON_MARK   || lbyte == eaf_pkg::XOFF_MARK);
    advance = !special || esc_ph;
    if (special && !esc_ph) begin
      line_byte = eaf_pkg::ESC_MARK;
    end else if (esc_ph) begin
      line_byte = lbyte ^ eaf_pkg::ESC_XOR;
    end else begin
      line_byte = lbyte;
    end
  end

  // Step sequencing
  always_comb begin
    unique case (eff)
      eaf_pkg::STEP_OPTS, eaf_pkg::STEP_PAY: begin
        done      = !qstat.head.last;
        step_next = done ? eaf_pkg::STEP_START : eaf_pkg::STEP_CHK;
      end
      eaf_pkg::STEP_CHK: begin
        done      = 1'b1;
        step_next = eaf_pkg::STEP_START;
      end
      default: begin
        done      = 1'b0;
        step_next = step + 1'b1;
      end
    endcase
  end

  assign emit = qstat.valid && (!result_valid || result_ready);
  assign pop  = emit && advance && done;

  // Sequencer state and checksum accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= eaf_pkg::STEP_START;
      esc_ph <= 1'b0;
      sum    <= 8'd0;
    end else if (emit) begin
      esc_ph <= !advance;
      if (advance) begin
        step <= step_next;
        if (eff == eaf_pkg::STEP_START) begin
          sum <= 8'd0;
        end else if (summed) begin
          sum <= sum + lbyte;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.out_byte  <= line_byte;
      result.run_last  <= advance && done;
      result.frame_end <= (eff == eaf_pkg::STEP_CHK);
    end
  end

`ifndef SYNTHESIS
  // Second half of an escape pair only follows a shown marker byte
  assert property (@(posedge clk) disable iff (rst)
      esc_ph |-> (result_valid && result.out_byte == eaf_pkg::ESC_MARK))
    else $error("escape phase without marker on output");

  // A command in progress keeps its queue entry
  assert property (@(posedge clk) disable iff (rst)
      (step != eaf_pkg::STEP_START || esc_ph) |-> qstat.valid)
    else $error("sequencer mid-command with empty queue");

  // The stored step never reaches past the checksum
  assert property (@(posedge clk) disable iff (rst) step <= eaf_pkg::STEP_CHK)
    else $error("sequencer step out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/core/escaped_api_frame_encoder.sv
// Top level of the escaped transmit-request API frame encoder.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_ready   item (kind, length, byte)
//   result    out        result_valid / result_ready  result (byte, last, end)
//   cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The back-end sequencer puts out one line byte per cycle while the result
// side takes them: a start item gives the start marker and 16 header bytes
// (an empty frame's checksum follows at once), a payload item its byte, plus
// the checksum after the frame's last byte. A two-entry command queue lets
// the front accept items while the back is busy. Synchronous reset clears
// frame state, the queue and output valid; configuration registers return to
// their defaults. cfg is always ready.
`default_nettype none

module escaped_api_frame_encoder (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            item_valid,
  output logic                           item_ready,
  input  eaf_pkg::in_item_t              item,
  output logic                           result_valid,
  input  wire                            result_ready,
  output eaf_pkg::out_item_t             result,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [eaf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [eaf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  eaf_pkg::cfg_t   cfg;
  eaf_pkg::push_t  push;
  eaf_pkg::qstat_t qstat;
  logic            pop;

  assign cfg_ready = 1'b1;

  eaf_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  eaf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .qstat      (qstat),
    .push       (push)
  );

  eaf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .qstat (qstat)
  );

  eaf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .qstat        (qstat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the escaped API frame encoder: predicted line bytes vs result items.
module tb;

  localparam int LIMIT_CYCLES = 300000;
  localparam int QUIET_CYCLES = 60;
  localparam int RAND_PHASES  = 5;
  localparam int PHASE_ITEMS  = 26;
  localparam logic [eaf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {SINK_FULL, SINK_HALF, SINK_SPARSE, SINK_BURSTY} sink_mode_t;

  typedef struct packed {
    logic              drain_first;
    eaf_pkg::in_item_t it;
  } pend_t;

  logic                           clk          = 1'b0;
  logic                           rst          = 1'b1;
  logic                           item_valid   = 1'b0;
  logic                           item_ready;
  eaf_pkg::in_item_t              item         = '0;
  logic                           result_valid;
  logic                           result_ready = 1'b0;
  eaf_pkg::out_item_t             result;
  logic                           cfg_valid    = 1'b0;
  logic                           cfg_ready;
  logic [eaf_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [eaf_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

  // Stimulus side
  pend_t      pend_q[$];
  pend_t      nxt;
  logic       item_taken = 1'b0;
  logic       cfg_taken  = 1'b0;
  int         gap_left   = 0;
  int         burst_left = 0;
  logic       gen_open   = 1'b0;
  logic [7:0] gen_left   = '0;
  int         stim_count = 0;

  // Receiver stall pattern
  sink_mode_t sink_mode = SINK_FULL;
  int         sink_left = 0;
  logic [7:0] sink_tick = '0;

  // Predictor state: shadow registers and frame progress
  eaf_pkg::cfg_t      shadow_cfg;
  logic [7:0]         ck_sum     = '0;
  logic [7:0]         pay_left   = '0;
  logic               frame_open = 1'b0;
  logic [7:0]         lb_byte[0:39];
  logic               lb_end[0:39];
  int                 lb_n;
  eaf_pkg::out_item_t line_q[$];
  eaf_pkg::out_item_t want;

  int err_count   = 0;
  int cycle_count = 0;

  escaped_api_frame_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Line byte builders for one item
  task automatic put_line(input logic [7:0] b, input logic fend);
    lb_byte[lb_n] = b;
    lb_end[lb_n]  = fend;
    lb_n++;
  endtask

  task automatic put_escaped(input logic [7:0] b, input logic fend);
    if (b == eaf_pkg::START_MARK || b == eaf_pkg::ESC_MARK ||
        b == eaf_pkg::XON_MARK || b == eaf_pkg::XOFF_MARK) begin
      put_line(eaf_pkg::ESC_MARK, fend);
      put_line(b ^ eaf_pkg::ESC_XOR, fend);
    end else begin
      put_line(b, fend);
    end
  endtask

  task automatic put_summed(input logic [7:0] b);
    ck_sum = ck_sum + b;
    put_escaped(b, 1'b0);
  endtask

  task automatic put_checksum();
    put_escaped(eaf_pkg::CHK_BASE - ck_sum, 1'b1);
    frame_open = 1'b0;
    pay_left   = '0;
  endtask

  // Expected line bytes of one accepted item
  task automatic predict_item(input eaf_pkg::in_item_t it);
    logic [15:0]        flen;
    eaf_pkg::out_item_t r;
    int                 k;
    lb_n = 0;
    if (it.kind == eaf_pkg::KIND_START) begin
      flen   = {8'h00, it.payload_length} + {7'd0, eaf_pkg::HDR_EXTRA};
      ck_sum = '0;
      put_line(eaf_pkg::START_MARK, 1'b0);
      put_escaped(flen[15:8], 1'b0);
      put_escaped(flen[7:0], 1'b0);
      put_summed(shadow_cfg.frame_type);
      put_summed(shadow_cfg.frame_ident);
      for (k = 3; k >= 0; k--) put_summed(shadow_cfg.dest_addr_high[8*k +: 8]);
      for (k = 3; k >= 0; k--) put_summed(shadow_cfg.dest_addr_low[8*k +: 8]);
      put_summed(shadow_cfg.dest_net_addr[15:8]);
      put_summed(shadow_cfg.dest_net_addr[7:0]);
      put_summed(shadow_cfg.hop_radius);
      put_summed(shadow_cfg.tx_options);
      if (it.payload_length == 8'd0) begin
        put_checksum();
      end else begin
        pay_left   = it.payload_length;
        frame_open = 1'b1;
      end
    end else if (frame_open) begin
      put_summed(it.payload_byte);
      pay_left = pay_left - 8'd1;
      if (pay_left == 8'd0) put_checksum();
    end
    for (k = 0; k < lb_n; k++) begin
      r.out_byte  = lb_byte[k];
      r.run_last  = (k == lb_n - 1);
      r.frame_end = lb_end[k];
      line_q.push_back(r);
    end
  endtask

  // Monitor: register shadow, prediction on accepted items, check of results
  always @(posedge clk) begin
    item_taken <= item_valid && item_ready && !rst;
    cfg_taken  <= cfg_valid && cfg_ready && !rst;
    if (rst) begin
      shadow_cfg.dest_addr_high = '0;
      shadow_cfg.dest_addr_low  = '0;
      shadow_cfg.dest_net_addr  = 16'hFFFE;
      shadow_cfg.hop_radius     = '0;
      shadow_cfg.tx_options     = '0;
      shadow_cfg.frame_type     = 8'h10;
      shadow_cfg.frame_ident    = 8'h01;
      ck_sum     = '0;
      pay_left   = '0;
      frame_open = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          eaf_pkg::REG_DEST_HIGH: shadow_cfg.dest_addr_high = cfg_data;
          eaf_pkg::REG_DEST_LOW:  shadow_cfg.dest_addr_low  = cfg_data;
          eaf_pkg::REG_NET_ADDR:  shadow_cfg.dest_net_addr  = cfg_data[15:0];
          eaf_pkg::REG_RADIUS:    shadow_cfg.hop_radius     = cfg_data[7:0];
          eaf_pkg::REG_OPTIONS:   shadow_cfg.tx_options     = cfg_data[7:0];
          eaf_pkg::REG_FRAME_TYP: shadow_cfg.frame_type     = cfg_data[7:0];
          eaf_pkg::REG_FRAME_ID:  shadow_cfg.frame_ident    = cfg_data[7:0];
          default: ;
        endcase
      end
      // predict first: a result in the same cycle still belongs to an older item
      if (item_valid && item_ready) predict_item(item);
      if (result_valid && result_ready) begin
        if (line_q.size() == 0) begin
          flag_error($sformatf("result byte %02h with none expected", result.out_byte));
        end else begin
          want = line_q.pop_front();
          if (result.out_byte !== want.out_byte)
            flag_error($sformatf("out_byte %02h, expected %02h",
                                 result.out_byte, want.out_byte));
          if (result.run_last !== want.run_last)
            flag_error($sformatf("run_last %b, expected %b (byte %02h)",
                                 result.run_last, want.run_last, want.out_byte));
          if (result.frame_end !== want.frame_end)
            flag_error($sformatf("frame_end %b, expected %b (byte %02h)",
                                 result.frame_end, want.frame_end, want.out_byte));
        end
      end
    end
  end

  // Item driver: bursts from the pending queue with random gaps
  always @(negedge clk) begin
    if (!rst && (!item_valid || item_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        nxt = pend_q[0];
        if (nxt.drain_first && line_q.size() != 0) begin
          // hold off until every pending line byte is out
          item_valid <= 1'b0;
        end else begin
          nxt = pend_q.pop_front();
          item       <= nxt.it;
          item_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall modes that change at random
  always @(negedge clk) begin
    sink_tick = sink_tick + 8'd1;
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(16, 120);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SINK_FULL:   result_ready <= 1'b1;
      SINK_HALF:   result_ready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
      default:     result_ready <= (sink_tick[3] == 1'b0);
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** escaped_api_frame_encoder: FAILED **");
      $finish;
    end
  end

  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0:       pick_byte = eaf_pkg::START_MARK;
      1:       pick_byte = eaf_pkg::ESC_MARK;
      2:       pick_byte = eaf_pkg::XON_MARK;
      3:       pick_byte = eaf_pkg::XOFF_MARK;
      4:       pick_byte = 8'h00;
      5:       pick_byte = 8'hFF;
      default: pick_byte = 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Queue one item; the unused field gets random content
  task automatic queue_item(input logic kind, input logic [7:0] value, input logic drain);
    eaf_pkg::in_item_t it;
    it.kind = kind;
    if (kind == eaf_pkg::KIND_START) begin
      it.payload_length = value;
      it.payload_byte   = 8'($urandom_range(0, 255));
      gen_open = (value != 8'd0);
      gen_left = value;
      stim_count++;
    end else begin
      it.payload_length = 8'($urandom_range(0, 241));
      it.payload_byte   = value;
      if (gen_open) begin
        stim_count++;
        gen_left = gen_left - 8'd1;
        if (gen_left == 8'd0) gen_open = 1'b0;
      end
    end
    pend_q.push_back({drain, it});
  endtask

  task automatic write_reg(input logic [eaf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [eaf_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(posedge clk);
      #1;
    end while (!cfg_taken);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] dh, input logic [31:0] dl, input logic [31:0] net,
                           input logic [31:0] rad, input logic [31:0] opt,
                           input logic [31:0] ftyp, input logic [31:0] fid);
    write_reg(eaf_pkg::REG_DEST_HIGH, dh);
    write_reg(eaf_pkg::REG_DEST_LOW, dl);
    write_reg(eaf_pkg::REG_NET_ADDR, net);
    write_reg(eaf_pkg::REG_RADIUS, rad);
    write_reg(eaf_pkg::REG_OPTIONS, opt);
    write_reg(eaf_pkg::REG_FRAME_TYP, ftyp);
    write_reg(eaf_pkg::REG_FRAME_ID, fid);
  endtask

  // Wait until every item is in and every line byte is out, then let the block settle
  task automatic wait_quiet();
    do begin
      @(posedge clk);
      #1;
    end while (pend_q.size() != 0 || item_valid || line_q.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] esc_vals[4];
    logic [7:0] hsum;
    logic [7:0] pay;
    int         ph;
    int         k;
    int         n;
    int         len;
    int         pick;

    esc_vals[0] = eaf_pkg::START_MARK;
    esc_vals[1] = eaf_pkg::ESC_MARK;
    esc_vals[2] = eaf_pkg::XON_MARK;
    esc_vals[3] = eaf_pkg::XOFF_MARK;

    // Reset defaults: empty frame, stray byte while idle, escaped payload,
    // longest length abandoned by a new start
    queue_item(eaf_pkg::KIND_START, 8'd0, 1'b0);
    queue_item(eaf_pkg::KIND_PAYLOAD, 8'h7E, 1'b0);
    queue_item(eaf_pkg::KIND_START, 8'd2, 1'b0);
    queue_item(eaf_pkg::KIND_PAYLOAD, eaf_pkg::START_MARK, 1'b0);
    queue_item(eaf_pkg::KIND_PAYLOAD, eaf_pkg::ESC_MARK, 1'b1);
    queue_item(eaf_pkg::KIND_START, 8'd3, 1'b0);
    queue_item(eaf_pkg::KIND_PAYLOAD, eaf_pkg::XON_MARK, 1'b0);
    queue_item(eaf_pkg::KIND_PAYLOAD, eaf_pkg::XOFF_MARK, 1'b0);
    queue_item(eaf_pkg::KIND_PAYLOAD, 8'hFF, 1'b0);
    queue_item(eaf_pkg::KIND_START, 8'd241, 1'b0);
    queue_item(eaf_pkg::KIND_PAYLOAD, 8'h00, 1'b0);
    queue_item(eaf_pkg::KIND_START, 8'd1, 1'b0);
    queue_item(eaf_pkg::KIND_PAYLOAD, 8'h55, 1'b0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every header byte an escape code; upper bits of narrow registers are junk
    wait_quiet();
    write_all({eaf_pkg::START_MARK, eaf_pkg::ESC_MARK, eaf_pkg::XON_MARK, eaf_pkg::XOFF_MARK},
              {eaf_pkg::XOFF_MARK, eaf_pkg::START_MARK, eaf_pkg::XON_MARK, eaf_pkg::ESC_MARK},
              {16'($urandom), eaf_pkg::ESC_MARK, eaf_pkg::START_MARK},
              {24'($urandom), eaf_pkg::XON_MARK},
              {24'($urandom), eaf_pkg::XOFF_MARK},
              {24'($urandom), eaf_pkg::START_MARK},
              {24'($urandom), eaf_pkg::ESC_MARK});
    write_reg(REG_UNUSED, $urandom);
    hsum = 8'(4 * (eaf_pkg::START_MARK + eaf_pkg::ESC_MARK) +
              3 * (eaf_pkg::XON_MARK + eaf_pkg::XOFF_MARK));
    // length low byte hits each escape code
    for (k = 0; k < 4; k++)
      queue_item(eaf_pkg::KIND_START, esc_vals[k] - eaf_pkg::HDR_EXTRA[7:0], 1'b0);
    // checksum hits each escape code
    for (k = 0; k < 4; k++) begin
      pay = eaf_pkg::CHK_BASE - esc_vals[k] - hsum;
      queue_item(eaf_pkg::KIND_START, 8'd1, 1'b0);
      queue_item(eaf_pkg::KIND_PAYLOAD, pay, 1'b0);
    end

    // Random phases: all ones, all zeros, then random settings
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_quiet();
      if (ph == 0) begin
        write_all('1, '1, '1, '1, '1, '1, '1);
      end else if (ph == 1) begin
        write_all('0, '0, '0, '0, '0, '0, '0);
      end else begin
        write_all({pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                  {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                  {16'($urandom), pick_byte(), pick_byte()},
                  {24'($urandom), pick_byte()},
                  {24'($urandom), pick_byte()},
                  {24'($urandom), pick_byte()},
                  {24'($urandom), pick_byte()});
      end
      if ($urandom_range(0, 1) == 1) write_reg(REG_UNUSED, $urandom);
      stim_count = 0;
      while (stim_count < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          // well-formed frame
          len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 24);
          queue_item(eaf_pkg::KIND_START, 8'(len), ($urandom_range(0, 19) == 0));
          for (k = 0; k < len; k++) queue_item(eaf_pkg::KIND_PAYLOAD, pick_byte(), 1'b0);
        end else if (pick < 88) begin
          // broken frame: left open for the next start to abandon
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(231, 241) : $urandom_range(1, 12);
          queue_item(eaf_pkg::KIND_START, 8'(len), 1'b0);
          n = $urandom_range(0, (len > 4) ? 4 : len - 1);
          for (k = 0; k < n; k++) queue_item(eaf_pkg::KIND_PAYLOAD, pick_byte(), 1'b0);
        end else begin
          // stray payload bytes
          n = $urandom_range(1, 3);
          for (k = 0; k < n; k++) queue_item(eaf_pkg::KIND_PAYLOAD, pick_byte(), 1'b0);
        end
      end
    end

    wait_quiet();
    if (err_count == 0) begin
      $display("** escaped_api_frame_encoder: PASSED **");
    end else begin
      $display("** escaped_api_frame_encoder: FAILED **");
    end
    $finish;
  end

endmodule
